// ===== rtl/window_focus_navigator_assert.svh =====
// ----------------------------------------------------------------------------
// window_focus_navigator_assert
// Assertion macros used by the navigator controller (wfn_ctrl).
// ----------------------------------------------------------------------------
`ifndef WINDOW_FOCUS_NAVIGATOR_ASSERT_SVH
`define WINDOW_FOCUS_NAVIGATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define WFN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define WFN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/wfn_pkg.sv =====
// ----------------------------------------------------------------------------
// wfn_pkg
// Types and constants shared by the window focus navigator.
// ----------------------------------------------------------------------------
package wfn_pkg;
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_CYCLE = 2'd2;
	localparam logic [1:0] REQ_DIR   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	typedef struct packed {
		logic clear;
		logic load;
		logic latch;
		logic rd_en;
		logic cur_cap;
		logic cand_eval;
		logic best_clr;
	} wfn_cmd_t;

	typedef struct packed {
		logic id_match;
		logic overlap;
		logic better;
		logic eligible;
	} wfn_stat_t;
endpackage

// ===== rtl/wfn_datapath.sv =====
// ----------------------------------------------------------------------------
// wfn_datapath
// Rectangle table memory, current-entry and best-candidate registers and the
// compare logic for overlap and directional ordering.
// ----------------------------------------------------------------------------
module wfn_datapath #(
	parameter int CAPACITY = 64,
	parameter int AW = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wfn_pkg::wfn_cmd_t      cmd,
	input  logic [AW-1:0]          wr_addr,
	input  logic [AW-1:0]          rd_addr,
	input  logic [63:0]            window_id,
	input  logic signed [31:0]     left_x,
	input  logic signed [31:0]     top_y,
	input  logic [30:0]            rect_width,
	input  logic [30:0]            rect_height,
	input  logic [1:0]             direction,
	output wfn_pkg::wfn_stat_t     stat,
	output logic [63:0]            rd_id,
	output logic [63:0]            best_id
);
	import wfn_pkg::*;

	logic [63:0]        mem_id   [CAPACITY];
	logic signed [31:0] mem_left [CAPACITY];
	logic signed [31:0] mem_top  [CAPACITY];
	logic [30:0]        mem_w    [CAPACITY];
	logic [30:0]        mem_h    [CAPACITY];

	logic [63:0]        key_id_q;
	logic [1:0]         dir_q;
	logic signed [31:0] rd_left_q, rd_top_q;
	logic [30:0]        rd_w_q, rd_h_q;
	logic [63:0]        rd_id_q;
	logic signed [31:0] cur_left_q, cur_top_q;
	logic [30:0]        cur_w_q, cur_h_q;
	logic [63:0]        best_id_q;
	logic [33:0]        best_p_q, best_s_q;
	logic               have_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_id[wr_addr]   <= window_id;
			mem_left[wr_addr] <= left_x;
			mem_top[wr_addr]  <= top_y;
			mem_w[wr_addr]    <= rect_width;
			mem_h[wr_addr]    <= rect_height;
		end
		if (cmd.rd_en) begin
			rd_id_q   <= mem_id[rd_addr];
			rd_left_q <= mem_left[rd_addr];
			rd_top_q  <= mem_top[rd_addr];
			rd_w_q    <= mem_w[rd_addr];
			rd_h_q    <= mem_h[rd_addr];
		end
		if (cmd.latch) begin
			key_id_q <= window_id;
			dir_q    <= direction;
		end
		if (cmd.cur_cap) begin
			cur_left_q <= rd_left_q;
			cur_top_q  <= rd_top_q;
			cur_w_q    <= rd_w_q;
			cur_h_q    <= rd_h_q;
		end
	end

	logic signed [34:0] cl_e, cr_e, ct_e, cb_e, rl_e, rr_e, rt_e, rb_e;
	logic signed [34:0] dx, dy;
	logic [33:0]        adx, ady, p, s;
	logic               ok;

	always_comb begin
		cl_e = 35'(cur_left_q);
		ct_e = 35'(cur_top_q);
		rl_e = 35'(rd_left_q);
		rt_e = 35'(rd_top_q);
		cr_e = cl_e + 35'(cur_w_q);
		cb_e = ct_e + 35'(cur_h_q);
		rr_e = rl_e + 35'(rd_w_q);
		rb_e = rt_e + 35'(rd_h_q);
		dx = (rl_e + rr_e) - (cl_e + cr_e);
		dy = (rt_e + rb_e) - (ct_e + cb_e);
		adx = dx[34] ? 34'(-dx) : 34'(dx);
		ady = dy[34] ? 34'(-dy) : 34'(dy);
		case (dir_q)
			DIR_LEFT:  ok = dx[34];
			DIR_RIGHT: ok = !dx[34] && (dx != 35'sd0);
			DIR_UP:    ok = dy[34];
			default:   ok = !dy[34] && (dy != 35'sd0);
		endcase
		p = dir_q[1] ? ady : adx;
		s = dir_q[1] ? adx : ady;
		stat.id_match = (rd_id_q == key_id_q);
		stat.overlap  = (cr_e > rl_e) && (rr_e > cl_e) && (cb_e > rt_e) && (rb_e > ct_e);
		stat.eligible = ok && !stat.id_match;
		stat.better   = !have_q || (p < best_p_q) ||
			((p == best_p_q) && ((s < best_s_q) ||
			((s == best_s_q) && (rd_id_q < best_id_q))));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.best_clr) begin
			have_q <= 1'b0;
		end else if (cmd.cand_eval && stat.eligible && stat.better) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cand_eval && stat.eligible && stat.better) begin
			best_p_q  <= p;
			best_s_q  <= s;
			best_id_q <= rd_id_q;
		end
	end

	assign rd_id   = rd_id_q;
	assign best_id = have_q ? best_id_q : 64'd0;
endmodule

// ===== rtl/wfn_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfn_ctrl
// Sequencer: accepts a word, runs the table scans and presents the result.
// ----------------------------------------------------------------------------
module wfn_ctrl #(
	parameter int CAPACITY = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [63:0]        window_id,
	input  logic [30:0]        rect_width,
	input  logic [30:0]        rect_height,
	input  logic               forward,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [63:0]        found_id,
	output wfn_pkg::wfn_cmd_t  cmd,
	input  wfn_pkg::wfn_stat_t stat,
	input  logic [63:0]        rd_id,
	input  logic [63:0]        best_id,
	output logic [AW-1:0]      wr_addr,
	output logic [AW-1:0]      rd_addr
);
	import wfn_pkg::*;
	`include "window_focus_navigator_assert.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIND = 3'd1;
	localparam logic [2:0] S_CUR  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q, idx_q, cur_q, step_q, cnt_m1;
	logic          fwd_q, dir_q, pend_q;
	logic [1:0]    status_q;
	logic [63:0]   found_q;
	logic          acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status    = status_q;
	assign found_id  = found_q;
	assign acc       = in_valid && in_ready;
	assign wr_addr   = count_q[AW-1:0];
	assign cnt_m1    = count_q - CW'(1);

	// Next scan index: linear in directional mode, else cyclic, wrapping without a divider.
	logic [CW-1:0] nxt_idx;
	always_comb begin
		if (dir_q) begin
			nxt_idx = idx_q + CW'(1);
		end else if (fwd_q) begin
			nxt_idx = (idx_q == cnt_m1) ? '0 : idx_q + CW'(1);
		end else begin
			nxt_idx = (idx_q == '0) ? cnt_m1 : idx_q - CW'(1);
		end
	end
	assign rd_addr = idx_q[AW-1:0];

	logic bad_ld;
	assign bad_ld = (window_id == 64'd0) || (rect_width == 31'd0) || (rect_height == 31'd0);

	always_comb begin
		cmd = '0;
		cmd.latch     = acc;
		cmd.best_clr  = acc;
		cmd.load      = acc && (req_type == REQ_LOAD) && !bad_ld &&
			(count_q != CW'(CAPACITY));
		cmd.rd_en     = (state_q == S_FIND) || (state_q == S_SCAN) || (state_q == S_CUR);
		cmd.cur_cap   = (state_q == S_FIND) && pend_q && stat.id_match;
		cmd.cand_eval = (state_q == S_SCAN) && pend_q && dir_q;
	end

	// pend_q: read data of idx from the previous cycle is valid.
	logic [CW-1:0] pidx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			pidx_q   <= '0;
			cur_q    <= '0;
			step_q   <= '0;
			fwd_q    <= 1'b0;
			dir_q    <= 1'b0;
			pend_q   <= 1'b0;
			status_q <= ST_OK;
			found_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						found_q  <= '0;
						status_q <= ST_OK;
						fwd_q    <= forward;
						dir_q    <= (req_type == REQ_DIR);
						idx_q    <= '0;
						pend_q   <= 1'b0;
						state_q  <= S_OUT;
						case (req_type)
							REQ_CLEAR: count_q <= '0;
							REQ_LOAD: begin
								if (bad_ld) begin
									status_q <= ST_INVALID;
								end else if (count_q == CW'(CAPACITY)) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							default: begin
								if (count_q == '0) begin
									status_q <= ST_INVALID;
								end else begin
									state_q <= S_FIND;
								end
							end
						endcase
					end
				end
				S_FIND: begin
					pend_q <= 1'b1;
					pidx_q <= idx_q;
					idx_q  <= idx_q + CW'(1);
					if (pend_q && stat.id_match) begin
						cur_q   <= pidx_q;
						idx_q   <= pidx_q;
						pend_q  <= 1'b0;
						state_q <= S_CUR;
					end else if (pend_q && (pidx_q == cnt_m1)) begin
						pend_q <= 1'b0;
						if (dir_q) begin
							status_q <= ST_NOTFOUND;
							state_q  <= S_OUT;
						end else begin
							idx_q   <= '0;
							state_q <= S_CUR;
							cur_q   <= count_q;
						end
					end
				end
				S_CUR: begin
					if (cur_q == count_q) begin
						// Current id absent: entry 0 is answered, read lands now.
						if (pend_q) begin
							found_q <= rd_id;
							state_q <= S_OUT;
						end
						pend_q <= 1'b1;
					end else begin
						step_q  <= CW'(1);
						pend_q  <= 1'b0;
						status_q <= ST_NOTFOUND;
						idx_q   <= dir_q ? '0 : nxt_idx;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					pend_q <= 1'b1;
					pidx_q <= idx_q;
					idx_q  <= nxt_idx;
					step_q <= step_q + CW'(1);
					if (!dir_q && pend_q && stat.overlap) begin
						found_q  <= rd_id;
						status_q <= ST_OK;
						state_q  <= S_OUT;
					end else if (dir_q ? (pend_q && pidx_q == cnt_m1)
						: (step_q == count_q)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (dir_q) begin
						found_q  <= best_id;
						status_q <= (best_id != 64'd0) ? ST_OK : ST_NOTFOUND;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`WFN_ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	`WFN_ASSERT_IMP(a_ok_nonzero, clk, arst_n, out_valid && dir_q && status_q == ST_OK, found_q != 64'd0, "ok without id")
	`WFN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found_q), "result dropped")
endmodule

// ===== rtl/window_focus_navigator.sv =====
// ----------------------------------------------------------------------------
// window_focus_navigator
// Rectangle table with cyclic-overlap and directional focus queries.
// ----------------------------------------------------------------------------
// Channel | Handshake              | Payload
// input   | in_valid / in_ready    | req_type window_id left_x top_y rect_width ...
// output  | out_valid / out_ready  | status found_id
//
// Clear and load are accepted and then present their result. A query reads the
// table one entry a cycle through a registered memory port: a find scan for
// the current id, a set-up step, then a search scan and a completion step
// before the result; a failed find or an overlap hit cuts this short.
// Reset empties the table at once; entries need no clearing.
// A result is held until taken; no new word is accepted meanwhile.
// ----------------------------------------------------------------------------
module window_focus_navigator #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [63:0]        window_id,
	input  logic signed [31:0] left_x,
	input  logic signed [31:0] top_y,
	input  logic [30:0]        rect_width,
	input  logic [30:0]        rect_height,
	input  logic               forward,
	input  logic [1:0]         direction,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [63:0]        found_id
);
	import wfn_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 2);

	wfn_cmd_t      cmd;
	wfn_stat_t     stat;
	logic [63:0]   rd_id, best_id;
	logic [AW-1:0] wr_addr, rd_addr;

	wfn_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .window_id(window_id),
		.rect_width(rect_width), .rect_height(rect_height), .forward(forward),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_id(found_id),
		.cmd(cmd), .stat(stat), .rd_id(rd_id), .best_id(best_id),
		.wr_addr(wr_addr), .rd_addr(rd_addr)
	);

	wfn_datapath #(.CAPACITY(CAPACITY), .AW(AW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.wr_addr(wr_addr), .rd_addr(rd_addr),
		.window_id(window_id), .left_x(left_x), .top_y(top_y),
		.rect_width(rect_width), .rect_height(rect_height),
		.direction(direction),
		.stat(stat), .rd_id(rd_id), .best_id(best_id)
	);
endmodule
